### src/tked_pkg.sv
// Shared types and constants for the terminal key escape decoder.
// Holds event kinds, key codes, parser modes, byte constants, the timeout reset value and the result word.
// No dependencies.
package tked_pkg;

    // Event kinds on the op field
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_EOI  = 2'd2;

    // Key codes
    localparam logic [3:0] KEY_CHAR    = 4'd0;
    localparam logic [3:0] KEY_ENTER   = 4'd1;
    localparam logic [3:0] KEY_UP      = 4'd2;
    localparam logic [3:0] KEY_DOWN    = 4'd3;
    localparam logic [3:0] KEY_LEFT    = 4'd4;
    localparam logic [3:0] KEY_RIGHT   = 4'd5;
    localparam logic [3:0] KEY_HOME    = 4'd6;
    localparam logic [3:0] KEY_END     = 4'd7;
    localparam logic [3:0] KEY_ESCAPE  = 4'd8;
    localparam logic [3:0] KEY_UNKNOWN = 4'd9;
    localparam logic [3:0] KEY_EOI     = 4'd10;

    // Parser modes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_ESC   = 3'd1;
    localparam logic [2:0] MODE_CSI   = 3'd2;
    localparam logic [2:0] MODE_SS3   = 3'd3;
    localparam logic [2:0] MODE_DRAIN = 3'd4;

    // Byte constants
    localparam logic [7:0] BYTE_ESC       = 8'h1B;
    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] BYTE_PRINT_LO  = 8'h20;
    localparam logic [7:0] BYTE_DEL       = 8'h7F;
    localparam logic [7:0] BYTE_FINAL_LO  = 8'h40;
    localparam logic [7:0] BYTE_FINAL_HI  = 8'h7E;
    localparam logic [7:0] BYTE_LBRACKET  = 8'h5B;
    localparam logic [7:0] BYTE_CAP_O     = 8'h4F;
    localparam logic [7:0] BYTE_TILDE     = 8'h7E;
    localparam logic [7:0] BYTE_A         = 8'h41;
    localparam logic [7:0] BYTE_B         = 8'h42;
    localparam logic [7:0] BYTE_C         = 8'h43;
    localparam logic [7:0] BYTE_D         = 8'h44;
    localparam logic [7:0] BYTE_F         = 8'h46;
    localparam logic [7:0] BYTE_H         = 8'h48;
    localparam logic [7:0] BYTE_DIGIT_1   = 8'h31;
    localparam logic [7:0] BYTE_DIGIT_4   = 8'h34;
    localparam logic [7:0] BYTE_DIGIT_7   = 8'h37;
    localparam logic [7:0] BYTE_DIGIT_8   = 8'h38;

    // Timeout register reset value
    localparam logic [15:0] TIMEOUT_RESET = 16'd50;

    // One result word
    typedef struct packed {
        logic [3:0] key;
        logic [6:0] char_code;
        logic       last;
    } result_t;

endpackage

### src/terminal_key_escape_decoder.sv
// Terminal key escape decoder: turns byte, tick and end-of-input events into key words.
// Parser state and a small result queue live here; depends on tked_pkg.
//
// Channel   Signals                               Word
// --------  ------------------------------------  ------------------------------
// input     in_valid, in_ready                    op, in_byte
// output    out_valid, out_ready                  key, char_code, last
// config    cfg_we                                cfg_wdata (timeout in ticks)
//
// Each input word is decoded in the cycle it is accepted; its results enter a
// four-entry result queue and appear on the output from the next cycle.
// One input word per cycle is taken while the queue has room for two results.
// End of input gives two results only after a result-free event left a sequence open, so with
// the output always ready the queue holds at most two and the input never stalls.
// Output stalls back up through the queue to in_ready. Reset puts the parser
// in idle, empties the queue and loads the timeout with 50.
module terminal_key_escape_decoder
    import tked_pkg::*;
#(
    parameter int MAX_SEQ_BYTES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // input events
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  in_byte,
    // key words
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  key,
    output logic [6:0]  char_code,
    output logic        last
);

    localparam logic [4:0] MAX_SEQ    = 5'(MAX_SEQ_BYTES);
    localparam logic [4:0] CNT_SAT    = 5'd31;
    localparam int         FIFO_DEPTH = 4;
    localparam int         PTR_W      = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W:0] FILL_LIMIT = (PTR_W+1)'(FIFO_DEPTH - 2);

    // Parser state
    logic [15:0] timeout_reg;
    logic [2:0]  mode_reg, mode_next;
    logic [4:0]  param_count_reg, param_count_next;
    logic [7:0]  first_param_reg, first_param_next;
    logic [15:0] idle_ticks_reg, idle_ticks_next;
    logic [4:0]  drain_count_reg, drain_count_next;

    // Result queue
    result_t          fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    logic       in_fire;
    logic       out_fire;
    logic [1:0] n_res;
    result_t    res0;
    result_t    res1;
    logic       clear_all;
    logic       enter_esc;
    logic [15:0] ticks_sat;
    logic [4:0]  param_inc;
    logic [4:0]  drain_inc;
    logic        is_final;
    logic [3:0]  abandon_key;
    logic [3:0]  csi_key;

    function automatic logic [3:0] letter_key(input logic [7:0] b);
        logic [3:0] k;
        case (b)
            BYTE_A:  k = KEY_UP;
            BYTE_B:  k = KEY_DOWN;
            BYTE_C:  k = KEY_RIGHT;
            BYTE_D:  k = KEY_LEFT;
            BYTE_H:  k = KEY_HOME;
            BYTE_F:  k = KEY_END;
            default: k = KEY_UNKNOWN;
        endcase
        return k;
    endfunction

    assign in_ready  = (count_reg <= FILL_LIMIT);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign out_fire  = out_valid && out_ready;

    assign key       = fifo_reg[rd_ptr_reg].key;
    assign char_code = fifo_reg[rd_ptr_reg].char_code;
    assign last      = fifo_reg[rd_ptr_reg].last;

    // Helpers for the decode
    assign is_final    = (in_byte >= BYTE_FINAL_LO) && (in_byte <= BYTE_FINAL_HI);
    assign ticks_sat   = (idle_ticks_reg != 16'hFFFF) ? idle_ticks_reg + 16'd1 : idle_ticks_reg;
    assign param_inc   = (param_count_reg < CNT_SAT) ? param_count_reg + 5'd1 : param_count_reg;
    assign drain_inc   = (drain_count_reg < CNT_SAT) ? drain_count_reg + 5'd1 : drain_count_reg;
    assign abandon_key = (mode_reg == MODE_ESC) ? KEY_ESCAPE : KEY_UNKNOWN;

    // CSI final byte: letters with no parameters, or one-digit tilde forms
    always_comb
    begin
        csi_key = KEY_UNKNOWN;
        if (param_count_reg == 5'd0)
        begin
            csi_key = letter_key(in_byte);
        end
        else if (in_byte == BYTE_TILDE && param_count_reg == 5'd1)
        begin
            if (first_param_reg == BYTE_DIGIT_1 || first_param_reg == BYTE_DIGIT_7)
            begin
                csi_key = KEY_HOME;
            end
            else if (first_param_reg == BYTE_DIGIT_4 || first_param_reg == BYTE_DIGIT_8)
            begin
                csi_key = KEY_END;
            end
        end
    end

    // Event decode and next parser state
    always_comb
    begin
        mode_next        = mode_reg;
        param_count_next = param_count_reg;
        first_param_next = first_param_reg;
        idle_ticks_next  = idle_ticks_reg;
        drain_count_next = drain_count_reg;
        n_res            = 2'd0;
        res0             = '{key: KEY_UNKNOWN, char_code: 7'd0, last: 1'b1};
        res1             = '{key: KEY_EOI, char_code: 7'd0, last: 1'b1};
        clear_all        = 1'b0;
        enter_esc        = 1'b0;

        if (in_fire)
        begin
            case (op)
                OP_TICK:
                begin
                    if (mode_reg != MODE_IDLE)
                    begin
                        idle_ticks_next = ticks_sat;
                        if (ticks_sat >= timeout_reg)
                        begin
                            res0.key  = abandon_key;
                            n_res     = 2'd1;
                            clear_all = 1'b1;
                        end
                    end
                end
                OP_EOI:
                begin
                    if (mode_reg == MODE_IDLE)
                    begin
                        res0.key = KEY_EOI;
                        n_res    = 2'd1;
                    end
                    else
                    begin
                        res0.key  = abandon_key;
                        res0.last = 1'b0;
                        n_res     = 2'd2;
                    end
                    clear_all = 1'b1;
                end
                OP_BYTE:
                begin
                    idle_ticks_next = 16'd0;
                    unique case (mode_reg)
                        MODE_ESC:
                        begin
                            if (in_byte == BYTE_LBRACKET)
                            begin
                                mode_next        = MODE_CSI;
                                param_count_next = 5'd0;
                                first_param_next = 8'd0;
                            end
                            else if (in_byte == BYTE_CAP_O)
                            begin
                                mode_next = MODE_SS3;
                            end
                            else
                            begin
                                n_res     = 2'd1;
                                clear_all = 1'b1;
                            end
                        end
                        MODE_CSI:
                        begin
                            if (is_final)
                            begin
                                res0.key  = csi_key;
                                n_res     = 2'd1;
                                clear_all = 1'b1;
                            end
                            else
                            begin
                                if (param_count_reg == 5'd0)
                                begin
                                    first_param_next = in_byte;
                                end
                                param_count_next = param_inc;
                                if (param_inc >= MAX_SEQ)
                                begin
                                    mode_next        = MODE_DRAIN;
                                    drain_count_next = 5'd0;
                                end
                            end
                        end
                        MODE_SS3:
                        begin
                            res0.key  = letter_key(in_byte);
                            n_res     = 2'd1;
                            clear_all = 1'b1;
                        end
                        MODE_DRAIN:
                        begin
                            drain_count_next = drain_inc;
                            if (is_final || drain_inc >= MAX_SEQ)
                            begin
                                n_res     = 2'd1;
                                clear_all = 1'b1;
                            end
                        end
                        default:
                        begin
                            // idle: plain bytes
                            clear_all = 1'b1;
                            if (in_byte == BYTE_ESC)
                            begin
                                enter_esc = 1'b1;
                            end
                            else if (in_byte == BYTE_CR || in_byte == BYTE_LF)
                            begin
                                res0.key = KEY_ENTER;
                                n_res    = 2'd1;
                            end
                            else if (in_byte >= BYTE_PRINT_LO && in_byte < BYTE_DEL)
                            begin
                                res0.key       = KEY_CHAR;
                                res0.char_code = in_byte[6:0];
                                n_res          = 2'd1;
                            end
                            else
                            begin
                                n_res = 2'd1;
                            end
                        end
                    endcase
                end
                default:
                begin
                    // undefined event kind: ignored
                end
            endcase
        end

        // Return to idle, then optionally start an escape
        if (clear_all)
        begin
            mode_next        = MODE_IDLE;
            param_count_next = 5'd0;
            first_param_next = 8'd0;
            idle_ticks_next  = 16'd0;
            drain_count_next = 5'd0;
        end
        if (enter_esc)
        begin
            mode_next = MODE_ESC;
        end
    end

    // Timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            param_count_reg <= 5'd0;
            first_param_reg <= 8'd0;
            idle_ticks_reg  <= 16'd0;
            drain_count_reg <= 5'd0;
        end
        else
        begin
            mode_reg        <= mode_next;
            param_count_reg <= param_count_next;
            first_param_reg <= first_param_next;
            idle_ticks_reg  <= idle_ticks_next;
            drain_count_reg <= drain_count_next;
        end
    end

    // Result queue storage
    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (n_res == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    // Result queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_res);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(out_fire);
            count_reg  <= count_reg + (PTR_W+1)'(n_res) - (PTR_W+1)'(out_fire);
        end
    end

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_param_bound: assert property (@(posedge clk) disable iff (!rst_n)
        param_count_reg <= MAX_SEQ)
        else $error("CSI parameter count beyond limit");

    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_DRAIN) |-> (drain_count_reg < MAX_SEQ))
        else $error("drain count reached limit without leaving drain");

    a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op == OP_EOI) |=> (mode_reg == MODE_IDLE))
        else $error("parser not idle after end of input");

endmodule

### dv/testbench.sv
// Self-checking testbench for terminal_key_escape_decoder: directed key sequences, then
// random event streams under several timeout settings, with bursty input and output stalls.
// Depends on tked_pkg and the decoder RTL.
module testbench
    import tked_pkg::*;
();

    localparam int SEQ_MAX = 16;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 4;
    // Fourth event kind, which the decoder ignores
    localparam logic [1:0] OP_NONE = 2'd3;

    // Mirror of the decoder: parser state, timeout and the queue of key words still due
    class key_scoreboard;
        result_t     want_q[$];
        int          errors;
        logic [15:0] timeout;
        logic [2:0]  mode;
        logic [4:0]  n_params;
        logic [7:0]  first_param;
        logic [15:0] ticks;
        logic [4:0]  drained;

        function new();
            errors  = 0;
            timeout = TIMEOUT_RESET;
            clear_parse();
        endfunction

        function void clear_parse();
            mode        = MODE_IDLE;
            n_params    = 5'd0;
            first_param = 8'd0;
            ticks       = 16'd0;
            drained     = 5'd0;
        endfunction

        function void push(logic [3:0] k, logic [6:0] c, logic l);
            result_t w;
            w.key       = k;
            w.char_code = c;
            w.last      = l;
            want_q = {want_q, w};
        endfunction

        function bit is_final(logic [7:0] b);
            return b >= BYTE_FINAL_LO && b <= BYTE_FINAL_HI;
        endfunction

        function logic [3:0] letter_key(logic [7:0] b);
            case (b)
                BYTE_A:  return KEY_UP;
                BYTE_B:  return KEY_DOWN;
                BYTE_C:  return KEY_RIGHT;
                BYTE_D:  return KEY_LEFT;
                BYTE_H:  return KEY_HOME;
                BYTE_F:  return KEY_END;
                default: return KEY_UNKNOWN;
            endcase
        endfunction

        function logic [3:0] csi_key(logic [7:0] fin);
            if (n_params == 5'd0)
                return letter_key(fin);
            if (fin == BYTE_TILDE && n_params == 5'd1) begin
                if (first_param == BYTE_DIGIT_1 || first_param == BYTE_DIGIT_7)
                    return KEY_HOME;
                if (first_param == BYTE_DIGIT_4 || first_param == BYTE_DIGIT_8)
                    return KEY_END;
            end
            return KEY_UNKNOWN;
        endfunction

        // Bare ESC gives escape, any other pending sequence unknown
        function logic [3:0] abandon_key();
            logic [3:0] k;
            k = (mode == MODE_ESC) ? KEY_ESCAPE : KEY_UNKNOWN;
            clear_parse();
            return k;
        endfunction

        function void decode_byte(logic [7:0] b);
            logic [3:0] k;
            ticks = 16'd0;
            case (mode)
                MODE_ESC:
                begin
                    if (b == BYTE_LBRACKET) begin
                        mode        = MODE_CSI;
                        n_params    = 5'd0;
                        first_param = 8'd0;
                    end else if (b == BYTE_CAP_O) begin
                        mode = MODE_SS3;
                    end else begin
                        clear_parse();
                        push(KEY_UNKNOWN, 7'd0, 1'b1);
                    end
                end
                MODE_CSI:
                begin
                    if (is_final(b)) begin
                        k = csi_key(b);
                        clear_parse();
                        push(k, 7'd0, 1'b1);
                    end else begin
                        if (n_params == 5'd0)
                            first_param = b;
                        if (n_params < 5'd31)
                            n_params++;
                        if (n_params >= SEQ_MAX) begin
                            mode    = MODE_DRAIN;
                            drained = 5'd0;
                        end
                    end
                end
                MODE_SS3:
                begin
                    k = letter_key(b);
                    clear_parse();
                    push(k, 7'd0, 1'b1);
                end
                MODE_DRAIN:
                begin
                    if (drained < 5'd31)
                        drained++;
                    if (is_final(b) || drained >= SEQ_MAX) begin
                        clear_parse();
                        push(KEY_UNKNOWN, 7'd0, 1'b1);
                    end
                end
                default:
                begin
                    clear_parse();
                    if (b == BYTE_ESC)
                        mode = MODE_ESC;
                    else if (b == BYTE_CR || b == BYTE_LF)
                        push(KEY_ENTER, 7'd0, 1'b1);
                    else if (b >= BYTE_PRINT_LO && b < BYTE_DEL)
                        push(KEY_CHAR, b[6:0], 1'b1);
                    else
                        push(KEY_UNKNOWN, 7'd0, 1'b1);
                end
            endcase
        endfunction

        // One accepted input word
        function void note_event(logic [1:0] ev, logic [7:0] b);
            case (ev)
                OP_BYTE: decode_byte(b);
                OP_TICK:
                begin
                    if (mode != MODE_IDLE) begin
                        if (ticks != 16'hFFFF)
                            ticks++;
                        if (ticks >= timeout)
                            push(abandon_key(), 7'd0, 1'b1);
                    end
                end
                OP_EOI:
                begin
                    if (mode != MODE_IDLE)
                        push(abandon_key(), 7'd0, 1'b0);
                    push(KEY_EOI, 7'd0, 1'b1);
                end
                default: ;  // fourth event kind is ignored
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        // One accepted output word against the oldest expectation
        task check_word(logic [3:0] k, logic [6:0] c, logic l);
            result_t w;
            if (want_q.size() == 0) begin
                report($sformatf("unexpected word key=%0d char=%02h last=%0b", k, c, l));
                return;
            end
            w = want_q.pop_front();
            if (k !== w.key)
                report($sformatf("key %0d, want %0d", k, w.key));
            if (c !== w.char_code)
                report($sformatf("char_code %02h, want %02h", c, w.char_code));
            if (l !== w.last)
                report($sformatf("last %0b, want %0b", l, w.last));
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [1:0]  op        = OP_BYTE;
    logic [7:0]  in_byte   = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  key;
    logic [6:0]  char_code;
    logic        last;

    key_scoreboard sb;
    int unsigned   cycles = 0;
    int unsigned   n_sent = 0;
    int unsigned   burst_left = 0;
    int unsigned   gap_max = 4;

    terminal_key_escape_decoder #(
        .MAX_SEQ_BYTES(SEQ_MAX)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .in_byte  (in_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .key      (key),
        .char_code(char_code),
        .last     (last)
    );

    always #2 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("terminal_key_escape_decoder regression: fail");
            $finish;
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(key, char_code, last);
    end

    // Receiver stalls: stretches of always-ready, coin flips, periodic and long stalls
    int unsigned rx_mode = 0, rx_left = 0, rx_period = 2, rx_count = 0, rx_hold = 0;
    always @(posedge clk)
    begin
        if (rx_left == 0) begin
            rx_mode   = $urandom_range(0, 3);
            rx_left   = $urandom_range(20, 200);
            rx_period = $urandom_range(2, 7);
        end else begin
            rx_left--;
        end
        rx_count++;
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (rx_count % rx_period) != 0;
            default:
            begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    out_ready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_hold = $urandom_range(1, 20);
                    out_ready <= 1'b0;
                end else begin
                    out_ready <= 1'b1;
                end
            end
        endcase
    end

    // Present one word, hold it until accepted, then maybe idle between bursts
    task automatic send_word(input logic [1:0] ev, input logic [7:0] b);
        int unsigned gap;
        in_valid <= 1'b1;
        op       <= ev;
        in_byte  <= b;
        do @(posedge clk); while (!in_ready);
        n_sent++;
        sb.note_event(ev, b);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(OP_BYTE, b);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_word(OP_TICK, 8'($urandom));
    endtask

    // Byte inside a sequence, now and then preceded by a tick or two
    task automatic seq_byte(input logic [7:0] b);
        if ($urandom_range(0, 7) == 0)
            send_ticks($urandom_range(1, 2));
        send_byte(b);
    endtask

    // Register write only once the decoder has gone quiet
    task automatic write_timeout(input logic [15:0] v);
        in_valid <= 1'b0;
        while (sb.want_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        sb.timeout = v;
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] arrow_letter();
        case ($urandom_range(0, 5))
            0:       return BYTE_A;
            1:       return BYTE_B;
            2:       return BYTE_C;
            3:       return BYTE_D;
            4:       return BYTE_H;
            default: return BYTE_F;
        endcase
    endfunction

    // Non-final CSI byte: mostly digits and separators, sometimes anything outside 40..7E
    function automatic logic [7:0] param_byte();
        int unsigned v;
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(8'h30, 8'h3F));
        v = $urandom_range(0, 8'hC0);
        return (v < 8'h40) ? 8'(v) : 8'(v + 8'h3F);
    endfunction

    function automatic logic [7:0] tilde_digit();
        case ($urandom_range(0, 4))
            0:       return BYTE_DIGIT_1;
            1:       return BYTE_DIGIT_4;
            2:       return BYTE_DIGIT_7;
            3:       return BYTE_DIGIT_8;
            default: return param_byte();
        endcase
    endfunction

    // One random chunk of traffic: mostly well-formed sequences, some noise
    task automatic random_chunk();
        int unsigned pick, n;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            case ($urandom_range(0, 2))
                0:       send_byte(8'($urandom_range(8'h20, 8'h7E)));
                1:       send_byte($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
                default: send_byte(8'($urandom));
            endcase
        end else if (pick < 20) begin
            send_byte(BYTE_ESC);
            seq_byte(8'($urandom));
        end else if (pick < 38) begin
            send_byte(BYTE_ESC);
            seq_byte(BYTE_LBRACKET);
            seq_byte($urandom_range(0, 3) ? arrow_letter() : 8'($urandom_range(8'h40, 8'h7E)));
        end else if (pick < 50) begin
            send_byte(BYTE_ESC);
            seq_byte(BYTE_LBRACKET);
            seq_byte(tilde_digit());
            seq_byte($urandom_range(0, 3) ? BYTE_TILDE : 8'($urandom_range(8'h40, 8'h7E)));
        end else if (pick < 58) begin
            // long parameter lists, often past the limit into draining
            send_byte(BYTE_ESC);
            seq_byte(BYTE_LBRACKET);
            n = $urandom_range(2, 2 * SEQ_MAX + 2);
            repeat (n) seq_byte(param_byte());
            if ($urandom_range(0, 1))
                seq_byte(8'($urandom_range(8'h40, 8'h7E)));
        end else if (pick < 68) begin
            send_byte(BYTE_ESC);
            seq_byte(BYTE_CAP_O);
            seq_byte($urandom_range(0, 2) ? arrow_letter() : 8'($urandom));
        end else if (pick < 78) begin
            // partial sequence followed by ticks near the timeout, which often abandons it
            send_byte(BYTE_ESC);
            if ($urandom_range(0, 1)) begin
                send_byte($urandom_range(0, 1) ? BYTE_LBRACKET : BYTE_CAP_O);
                if ($urandom_range(0, 1))
                    send_byte(param_byte());
            end
            n = (sb.timeout > 58) ? 60 : sb.timeout + $urandom_range(0, 2);
            send_ticks((n == 0) ? 1 : n - $urandom_range(0, 1));
        end else if (pick < 86) begin
            send_ticks($urandom_range(1, 5));
        end else if (pick < 92) begin
            send_word(OP_EOI, 8'($urandom));
        end else if (pick < 96) begin
            send_word(OP_NONE, 8'($urandom));
        end else begin
            send_byte(BYTE_ESC);
            if ($urandom_range(0, 1)) begin
                seq_byte(BYTE_LBRACKET);
                repeat ($urandom_range(0, SEQ_MAX + 3)) seq_byte(param_byte());
            end
            send_word(OP_EOI, 8'($urandom));
        end
    endtask

    logic [15:0] phase_timeout[6] = '{16'd1, 16'd3, 16'd0, 16'd7, 16'd2, 16'd50};
    int unsigned goal;

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset timeout of 50
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(BYTE_PRINT_LO);
        send_byte(BYTE_FINAL_HI);
        send_byte(BYTE_DEL);
        send_byte(BYTE_CR);
        send_byte(BYTE_LF);
        send_byte(BYTE_ESC);
        send_byte(8'h78);
        send_byte(BYTE_ESC);
        send_byte(BYTE_LBRACKET);
        send_byte(BYTE_A);
        send_byte(BYTE_ESC);
        send_byte(BYTE_LBRACKET);
        send_byte(BYTE_DIGIT_1);
        send_byte(BYTE_TILDE);
        send_byte(BYTE_ESC);
        send_byte(BYTE_CAP_O);
        send_byte(BYTE_F);
        send_byte(BYTE_ESC);
        send_word(OP_EOI, 8'h00);
        send_word(OP_EOI, 8'hFF);
        send_word(OP_TICK, 8'h00);
        send_word(OP_NONE, 8'hA5);

        // Random phases over several timeout settings
        for (int p = 0; p < 6; p++) begin
            write_timeout(phase_timeout[p]);
            gap_max = (p == 2) ? 0 : $urandom_range(1, 8);
            goal = n_sent + 235;
            while (n_sent < goal)
                random_chunk();
        end

        // Largest timeout: a bare escape outlives a short run of ticks and is
        // flushed by end of input; then a timeout of one abandons on one tick
        write_timeout(16'hFFFF);
        gap_max = 2;
        send_byte(BYTE_ESC);
        send_ticks($urandom_range(1, 20));
        send_word(OP_EOI, 8'h00);
        write_timeout(16'd1);
        send_byte(BYTE_ESC);
        send_ticks(1);

        // Drain and finish
        in_valid <= 1'b0;
        while (sb.want_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.want_q.size() == 0)
            $display("terminal_key_escape_decoder regression: pass");
        else
            $display("terminal_key_escape_decoder regression: fail");
        $finish;
    end

endmodule
